/* hw/rtl/mi4_pkg.sv */
// Shared types, widths and codes for the 4x4 matrix inverse core.
// Used by the cofactor lanes, the determinant merge, the divider and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mi4_pkg;

   // element and datapath widths
   localparam int ELEM_W        = 32;
   localparam int OPND_W        = 33;   // signed multiplier operand
   localparam int PROD_W        = 66;   // signed 33x33 product
   localparam int TERM_W        = 65;   // 2x2 minor
   localparam int LACC_W        = 98;   // lane accumulator
   localparam int COF_W         = 97;   // 3x3 cofactor
   localparam int DET_W         = 132;  // determinant accumulator
   localparam int QUOT_W        = 32;   // quotient bits kept
   localparam int FRAC_BITS_DEF = 16;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_SINGULAR  = 2'd1,
      STAT_SATURATED = 2'd2
   } status_type;

   // top level sequencer
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COF,
      ST_DET,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } core_state_type;

   // divider sequencer
   typedef enum logic [2:0] {
      DV_IDLE,
      DV_SUM,
      DV_CHECK,
      DV_ITER,
      DV_DONE
   } div_state_type;

   // control sent to all cofactor lanes
   typedef struct packed {
      logic       act;
      logic [1:0] row;
      logic [3:0] step;
   } lane_ctl_type;

   // cofactor leaving a lane
   typedef struct packed {
      logic                    valid;
      logic [1:0]              row;
      logic signed [COF_W-1:0] cof;
   } lane_res_type;

endpackage

/* hw/rtl/mi4_lane.sv */
// Cofactor lane: one column of the cofactor matrix, one cofactor per 12 steps.
// Shares one 33x33 signed multiplier and one accumulator. Depends on mi4_pkg.
`timescale 1ns / 1ps

module mi4_lane
   import mi4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               col_sel,
   input  logic signed [ELEM_W-1:0] mat [16],
   input  lane_ctl_type             ctl,
   output lane_res_type             res
);

   localparam logic [1:0] T0 = 2'd0;
   localparam logic [1:0] T1 = 2'd1;
   localparam logic [1:0] T2 = 2'd2;

   typedef struct packed {
      logic [1:0] xr;
      logic [1:0] xc;
      logic [1:0] yr;
      logic [1:0] yc;
      logic       yterm;
      logic [1:0] tsel;
      logic       yhi;
      logic       sub;
      logic       first;
      logic       store;
      logic       fin;
   } dec_type;

   typedef struct packed {
      logic       act;
      logic       first;
      logic       sub;
      logic       yhi;
      logic       store;
      logic       fin;
      logic [1:0] tsel;
      logic [1:0] row;
   } pipe_type;

   dec_type                    dec;
   pipe_type                   p_ff, p_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [LACC_W-1:0]   acc_ff, acc_in;
   logic signed [TERM_W-1:0]   t_ff [3];
   lane_res_type               res_ff, res_in;
   logic [1:0]                 xfr, xfc, yfr, yfc;
   logic signed [ELEM_W-1:0]   xe, ye;
   logic signed [TERM_W-1:0]   tv;
   logic signed [OPND_W-1:0]   x33, y33;
   logic signed [LACC_W-1:0]   addend, base, cof_val;

   // step decode: three 2x2 minors, then the 3x3 expansion along row 0
   always_comb begin
      dec = '0;
      case (ctl.step)
         4'd0: begin
            dec.xr = 2'd1; dec.xc = 2'd1; dec.yr = 2'd2; dec.yc = 2'd2; dec.first = 1'b1;
         end
         4'd1: begin
            dec.xr = 2'd1; dec.xc = 2'd2; dec.yr = 2'd2; dec.yc = 2'd1;
            dec.sub = 1'b1; dec.store = 1'b1; dec.tsel = T0;
         end
         4'd2: begin
            dec.xr = 2'd1; dec.xc = 2'd0; dec.yr = 2'd2; dec.yc = 2'd2; dec.first = 1'b1;
         end
         4'd3: begin
            dec.xr = 2'd1; dec.xc = 2'd2; dec.yr = 2'd2; dec.yc = 2'd0;
            dec.sub = 1'b1; dec.store = 1'b1; dec.tsel = T1;
         end
         4'd4: begin
            dec.xr = 2'd1; dec.xc = 2'd0; dec.yr = 2'd2; dec.yc = 2'd1; dec.first = 1'b1;
         end
         4'd5: begin
            dec.xr = 2'd1; dec.xc = 2'd1; dec.yr = 2'd2; dec.yc = 2'd0;
            dec.sub = 1'b1; dec.store = 1'b1; dec.tsel = T2;
         end
         4'd6: begin
            dec.xc = 2'd0; dec.yterm = 1'b1; dec.tsel = T0; dec.first = 1'b1;
         end
         4'd7: begin
            dec.xc = 2'd0; dec.yterm = 1'b1; dec.tsel = T0; dec.yhi = 1'b1;
         end
         4'd8: begin
            dec.xc = 2'd1; dec.yterm = 1'b1; dec.tsel = T1; dec.sub = 1'b1;
         end
         4'd9: begin
            dec.xc = 2'd1; dec.yterm = 1'b1; dec.tsel = T1; dec.yhi = 1'b1; dec.sub = 1'b1;
         end
         4'd10: begin
            dec.xc = 2'd2; dec.yterm = 1'b1; dec.tsel = T2;
         end
         4'd11: begin
            dec.xc = 2'd2; dec.yterm = 1'b1; dec.tsel = T2; dec.yhi = 1'b1; dec.fin = 1'b1;
         end
         default: dec = '0;
      endcase
   end

   // minor index to full matrix index: skip the cofactor's own row and column
   always_comb begin
      xfr = (dec.xr >= ctl.row) ? dec.xr + 2'd1 : dec.xr;
      yfr = (dec.yr >= ctl.row) ? dec.yr + 2'd1 : dec.yr;
      xfc = (dec.xc >= col_sel) ? dec.xc + 2'd1 : dec.xc;
      yfc = (dec.yc >= col_sel) ? dec.yc + 2'd1 : dec.yc;
      xe  = mat[{xfr, xfc}];
      ye  = mat[{yfr, yfc}];
      tv  = t_ff[dec.tsel];
      x33 = {xe[ELEM_W-1], xe};
      if (!dec.yterm) begin
         y33 = {ye[ELEM_W-1], ye};
      end else if (dec.yhi) begin
         y33 = tv[TERM_W-1:ELEM_W];
      end else begin
         y33 = {1'b0, tv[ELEM_W-1:0]};
      end
      prod_in     = x33 * y33;
      p_in.act    = ctl.act;
      p_in.first  = dec.first;
      p_in.sub    = dec.sub;
      p_in.yhi    = dec.yhi;
      p_in.store  = dec.store;
      p_in.fin    = dec.fin;
      p_in.tsel   = dec.tsel;
      p_in.row    = ctl.row;
   end

   // accumulate stage
   always_comb begin
      addend = LACC_W'(prod_ff);
      if (p_ff.yhi) begin
         addend = addend <<< ELEM_W;
      end
      base    = p_ff.first ? '0 : acc_ff;
      acc_in  = p_ff.sub ? base - addend : base + addend;
      cof_val = (p_ff.row[0] ^ col_sel[0]) ? -acc_in : acc_in;
      res_in.valid = p_ff.act & p_ff.fin;
      res_in.row   = p_ff.row;
      res_in.cof   = cof_val[COF_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (p_ff.act) begin
         acc_ff <= acc_in;
         if (p_ff.store) begin
            t_ff[p_ff.tsel] <= acc_in[TERM_W-1:0];
         end
      end
      res_ff.row <= res_in.row;
      res_ff.cof <= res_in.cof;
      if (reset) begin
         p_ff         <= '0;
         res_ff.valid <= 1'b0;
      end else begin
         p_ff         <= p_in;
         res_ff.valid <= res_in.valid;
      end
   end

   assign res = res_ff;

endmodule

/* hw/rtl/mi4_merge.sv */
// Determinant merge: sums row-0 elements times the row-0 cofactors from the lanes.
// One 33x33 multiplier, 12 steps. Depends on mi4_pkg.
`timescale 1ns / 1ps

module mi4_merge
   import mi4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [ELEM_W-1:0] mat [16],
   input  lane_res_type             lres [4],
   input  logic                     go,
   output logic                     det_valid,
   output logic signed [DET_W-1:0]  det
);

   logic signed [COF_W-1:0]  cof0_ff [4];
   logic                     run_ff, run_in;
   logic [1:0]               j_ff, j_in;
   logic [1:0]               ch_ff, ch_in;
   logic                     last;
   logic signed [ELEM_W-1:0] el;
   logic signed [COF_W-1:0]  cv;
   logic signed [OPND_W-1:0] x33, y33;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     p_act_ff, p_first_ff, p_last_ff;
   logic [1:0]               p_sh_ff;
   logic signed [DET_W-1:0]  acc_ff, acc_in, addend, base;
   logic                     dv_ff;

   // step counters: column j, 32-bit chunk of the cofactor
   always_comb begin
      last   = (j_ff == 2'd3) && (ch_ff == 2'd2);
      run_in = go | (run_ff & ~last);
      ch_in  = (go || !run_ff || ch_ff == 2'd2) ? 2'd0 : ch_ff + 2'd1;
      if (go || !run_ff) begin
         j_in = 2'd0;
      end else begin
         j_in = (ch_ff == 2'd2) ? j_ff + 2'd1 : j_ff;
      end
   end

   // multiply stage
   always_comb begin
      el  = mat[{2'b00, j_ff}];
      cv  = cof0_ff[j_ff];
      x33 = {el[ELEM_W-1], el};
      case (ch_ff)
         2'd0:    y33 = {1'b0, cv[ELEM_W-1:0]};
         2'd1:    y33 = {1'b0, cv[2*ELEM_W-1:ELEM_W]};
         default: y33 = cv[COF_W-1:2*ELEM_W];
      endcase
      prod_in = x33 * y33;
   end

   // accumulate stage
   always_comb begin
      addend = DET_W'(prod_ff);
      case (p_sh_ff)
         2'd0:    addend = addend;
         2'd1:    addend = addend <<< ELEM_W;
         default: addend = addend <<< (2 * ELEM_W);
      endcase
      base   = p_first_ff ? '0 : acc_ff;
      acc_in = base + addend;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         if (lres[j].valid && lres[j].row == 2'd0) begin
            cof0_ff[j] <= lres[j].cof;
         end
      end
      prod_ff    <= prod_in;
      p_first_ff <= (j_ff == 2'd0) && (ch_ff == 2'd0);
      p_sh_ff    <= ch_ff;
      p_last_ff  <= last;
      if (p_act_ff) begin
         acc_ff <= acc_in;
      end
      if (reset) begin
         run_ff   <= 1'b0;
         j_ff     <= 2'd0;
         ch_ff    <= 2'd0;
         p_act_ff <= 1'b0;
         dv_ff    <= 1'b0;
      end else begin
         run_ff   <= run_in;
         j_ff     <= j_in;
         ch_ff    <= ch_in;
         p_act_ff <= run_ff;
         dv_ff    <= p_act_ff & p_last_ff;
      end
   end

   assign det_valid = dv_ff;
   assign det       = acc_ff;

endmodule

/* hw/rtl/mi4_div.sv */
// Bit-serial divider: one rounded, saturated inverse element per run.
// Quotient = (|C| * 2^(2F+1) + |det|) / (2|det|), one bit per cycle. Depends on mi4_pkg.
`timescale 1ns / 1ps

module mi4_div
   import mi4_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic signed [COF_W-1:0]  cof,
   input  logic [DET_W-1:0]         det_abs,
   input  logic                     det_neg,
   output logic                     done,
   output logic signed [ELEM_W-1:0] res,
   output logic                     sat
);

   localparam int NUM_W = COF_W + 2 * FRAC_BITS + 1;
   localparam int DEN_W = DET_W + QUOT_W + 1;
   localparam int DIV_W = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
   localparam logic [QUOT_W-1:0] POS_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] NEG_MAX = {1'b1, {(QUOT_W-1){1'b0}}};

   div_state_type           state_ff, state_in;
   logic [COF_W-1:0]        cabs_ff, cabs_in;
   logic                    neg_ff, neg_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]        dsh_ff, dsh_in;
   logic [QUOT_W-1:0]       q_ff, q_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    big_ff, big_in;
   logic                    ge;
   logic                    done_ff, done_in;
   logic [ELEM_W-1:0]       res_ff, res_in;
   logic                    sat_ff, sat_in;
   logic [QUOT_W-1:0]       mag;

   always_comb begin
      state_in = state_ff;
      cabs_in  = cabs_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      big_in   = big_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      sat_in   = sat_ff;
      ge       = rem_ff >= dsh_ff;
      mag      = q_ff;
      case (state_ff)
         DV_IDLE: begin
            if (go) begin
               cabs_in  = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
               neg_in   = cof[COF_W-1] ^ det_neg;
               state_in = DV_SUM;
            end
         end
         // numerator with the rounding half added, divisor one place above the top quotient bit
         DV_SUM: begin
            rem_in   = (DIV_W'(cabs_ff) << (2 * FRAC_BITS + 1)) + DIV_W'(det_abs);
            dsh_in   = DIV_W'(det_abs) << (QUOT_W + 1);
            state_in = DV_CHECK;
         end
         // quotient of 2^32 or more saturates
         DV_CHECK: begin
            big_in   = ge;
            dsh_in   = dsh_ff >> 1;
            q_in     = '0;
            cnt_in   = '0;
            state_in = ge ? DV_DONE : DV_ITER;
         end
         DV_ITER: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in   = {q_ff[QUOT_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = DV_DONE;
            end
         end
         // sign and clamp
         DV_DONE: begin
            sat_in = 1'b0;
            if (neg_ff) begin
               if (big_ff || q_ff > NEG_MAX) begin
                  mag    = NEG_MAX;
                  sat_in = 1'b1;
               end
               res_in = ELEM_W'(-mag);
            end else begin
               if (big_ff || q_ff > POS_MAX) begin
                  mag    = POS_MAX;
                  sat_in = 1'b1;
               end
               res_in = mag;
            end
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cabs_ff <= cabs_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      big_ff  <= big_in;
      res_ff  <= res_in;
      sat_ff  <= sat_in;
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign sat  = sat_ff;

endmodule

/* hw/rtl/matrix_inverse_4x4_core.sv */
// Rows 1-3 are taken whenever start is high; after row 4 the core runs 48
// lane steps, 12 merge steps and 16 quotients in the shared bit-serial
// divider (skipped for a singular matrix), then sends the 4 inverse rows in
// consecutive cycles. One matrix at a time: busy is high from row 4 until
// the last row leaves. Synchronous active-high reset clears all control state.
`timescale 1ns / 1ps

module matrix_inverse_4x4_core
   import mi4_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [ELEM_W-1:0] req_elem0,
   input  logic signed [ELEM_W-1:0] req_elem1,
   input  logic signed [ELEM_W-1:0] req_elem2,
   input  logic signed [ELEM_W-1:0] req_elem3,
   output logic                     rsp_valid,
   output logic signed [ELEM_W-1:0] rsp_res0,
   output logic signed [ELEM_W-1:0] rsp_res1,
   output logic signed [ELEM_W-1:0] rsp_res2,
   output logic signed [ELEM_W-1:0] rsp_res3,
   output logic [1:0]               rsp_row_index,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   core_state_type           state_ff, state_in;
   logic [1:0]               rows_ff, rows_in;
   logic [1:0]               lrow_ff, lrow_in;
   logic [3:0]               lstep_ff, lstep_in;
   logic                     issue_ff, issue_in;
   logic [3:0]               kidx_ff, kidx_in;
   logic                     launch_ff, launch_in;
   logic [1:0]               orow_ff, orow_in;
   logic                     singular_ff, singular_in;
   logic                     sat_ff, sat_in;
   logic signed [DET_W-1:0]  det_ff;
   logic [DET_W-1:0]         det_abs_ff, det_abs_in;
   logic                     det_neg_ff, det_neg_in;
   logic signed [ELEM_W-1:0] mat_ff [16];
   logic signed [COF_W-1:0]  cof_ff [16];
   logic signed [ELEM_W-1:0] res_ff [16];
   logic                     accept;
   logic                     merge_go;
   logic                     det_valid;
   logic signed [DET_W-1:0]  det;
   logic                     div_go, div_done, div_sat;
   logic signed [ELEM_W-1:0] div_res;
   lane_ctl_type             lctl;
   lane_res_type             lres [4];
   status_type               status;

   assign accept = start & ~busy;
   assign busy   = (state_ff != ST_LOAD);

   // lane sequencer output
   always_comb begin
      lctl.act  = issue_ff;
      lctl.row  = lrow_ff;
      lctl.step = lstep_ff;
   end

   // four cofactor lanes, one per column
   for (genvar j = 0; j < 4; j++) begin : g_lane
      mi4_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .col_sel (2'(j)),
         .mat     (mat_ff),
         .ctl     (lctl),
         .res     (lres[j])
      );
   end

   mi4_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .mat       (mat_ff),
      .lres      (lres),
      .go        (merge_go),
      .det_valid (det_valid),
      .det       (det)
   );

   mi4_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .go      (div_go),
      .cof     (cof_ff[{kidx_ff[1:0], kidx_ff[3:2]}]),
      .det_abs (det_abs_ff),
      .det_neg (det_neg_ff),
      .done    (div_done),
      .res     (div_res),
      .sat     (div_sat)
   );

   // main sequencer
   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      lrow_in     = lrow_ff;
      lstep_in    = lstep_ff;
      issue_in    = issue_ff;
      kidx_in     = kidx_ff;
      launch_in   = 1'b0;
      orow_in     = orow_ff;
      singular_in = singular_ff;
      sat_in      = sat_ff;
      det_abs_in  = det_abs_ff;
      det_neg_in  = det_neg_ff;
      merge_go    = 1'b0;
      div_go      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               rows_in = rows_ff + 2'd1;
               if (rows_ff == 2'd3) begin
                  issue_in = 1'b1;
                  lrow_in  = 2'd0;
                  lstep_in = 4'd0;
                  state_in = ST_COF;
               end
            end
         end
         ST_COF: begin
            if (issue_ff) begin
               if (lstep_ff == 4'd11) begin
                  lstep_in = 4'd0;
                  lrow_in  = lrow_ff + 2'd1;
                  if (lrow_ff == 2'd3) begin
                     issue_in = 1'b0;
                  end
               end else begin
                  lstep_in = lstep_ff + 4'd1;
               end
            end
            if (lres[0].valid && lres[0].row == 2'd3) begin
               merge_go = 1'b1;
               state_in = ST_DET;
            end
         end
         ST_DET: begin
            if (det_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (det_ff == '0) begin
               singular_in = 1'b1;
               orow_in     = 2'd0;
               state_in    = ST_OUT;
            end else begin
               det_neg_in = det_ff[DET_W-1];
               det_abs_in = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
               kidx_in    = 4'd0;
               launch_in  = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_go = launch_ff;
            if (div_done) begin
               sat_in = sat_ff | div_sat;
               if (kidx_ff == 4'd15) begin
                  orow_in  = 2'd0;
                  state_in = ST_OUT;
               end else begin
                  kidx_in   = kidx_ff + 4'd1;
                  launch_in = 1'b1;
               end
            end
         end
         ST_OUT: begin
            orow_in = orow_ff + 2'd1;
            if (orow_ff == 2'd3) begin
               singular_in = 1'b0;
               sat_in      = 1'b0;
               state_in    = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // storage: matrix rows, cofactors, inverse elements
   always_ff @(posedge clock) begin
      if (accept) begin
         mat_ff[{rows_ff, 2'd0}] <= req_elem0;
         mat_ff[{rows_ff, 2'd1}] <= req_elem1;
         mat_ff[{rows_ff, 2'd2}] <= req_elem2;
         mat_ff[{rows_ff, 2'd3}] <= req_elem3;
      end
      for (int j = 0; j < 4; j++) begin
         if (lres[j].valid) begin
            cof_ff[{lres[j].row, 2'(j)}] <= lres[j].cof;
         end
      end
      if (det_valid) begin
         det_ff <= det;
      end
      if (div_done) begin
         res_ff[kidx_ff] <= div_res;
      end
      det_abs_ff <= det_abs_in;
      det_neg_ff <= det_neg_in;
      lrow_ff    <= lrow_in;
      lstep_ff   <= lstep_in;
      kidx_ff    <= kidx_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         rows_ff     <= 2'd0;
         issue_ff    <= 1'b0;
         launch_ff   <= 1'b0;
         orow_ff     <= 2'd0;
         singular_ff <= 1'b0;
         sat_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rows_ff     <= rows_in;
         issue_ff    <= issue_in;
         launch_ff   <= launch_in;
         orow_ff     <= orow_in;
         singular_ff <= singular_in;
         sat_ff      <= sat_in;
      end
   end

   // result item
   always_comb begin
      if (singular_ff) begin
         status = STAT_SINGULAR;
      end else if (sat_ff) begin
         status = STAT_SATURATED;
      end else begin
         status = STAT_OK;
      end
   end

   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_res0      = singular_ff ? '0 : res_ff[{orow_ff, 2'd0}];
   assign rsp_res1      = singular_ff ? '0 : res_ff[{orow_ff, 2'd1}];
   assign rsp_res2      = singular_ff ? '0 : res_ff[{orow_ff, 2'd2}];
   assign rsp_res3      = singular_ff ? '0 : res_ff[{orow_ff, 2'd3}];
   assign rsp_row_index = orow_ff;
   assign rsp_status    = status;
   assign rsp_last      = rsp_valid && (orow_ff == 2'd3);

   // results only while the matrix is being processed
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // the last row ends the burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid && !busy)
      else $error("result strobe after last row");

   // rows of one inverse come in consecutive cycles, in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("inverse rows out of order");

   // the fourth row starts the computation
   a_fourth_row: assert property (@(posedge clock) disable iff (reset)
      accept && rows_ff == 2'd3 |=> busy && rows_ff == 2'd0)
      else $error("fourth row did not start the inverse");

   // a singular matrix skips the divider
   a_singular: assert property (@(posedge clock) disable iff (reset)
      singular_ff |-> state_ff == ST_OUT)
      else $error("singular flag outside output phase");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for matrix_inverse_4x4_core: streams 4x4 matrices row by row and
// compares every inverse row against a fixed-point cofactor predictor.
// Depends on mi4_pkg and the core RTL.
`timescale 1ns / 1ps

// expected inverse rows, oldest first
class inverse_scoreboard;
   typedef struct {
      logic signed [31:0] res [4];
      logic [1:0]         row_index;
      logic [1:0]         status;
      logic               last;
   } inv_row_type;

   logic signed [31:0] elems [16];
   int unsigned        rows_in;
   inv_row_type        pending [$];
   int unsigned        mismatches;
   int unsigned        matrices;
   int unsigned        singulars;
   int unsigned        saturations;

   function new();
      rows_in = 0;
      mismatches = 0;
      matrices = 0;
      singulars = 0;
      saturations = 0;
   endfunction

   // signed 3x3 cofactor of element (r, c)
   function logic signed [127:0] cofactor(int r, int c);
      int rs [3];
      int cs [3];
      int n;
      logic signed [127:0] a [3][3];
      logic signed [127:0] d;
      n = 0;
      for (int i = 0; i < 4; i++) if (i != r) begin rs[n] = i; n++; end
      n = 0;
      for (int i = 0; i < 4; i++) if (i != c) begin cs[n] = i; n++; end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) a[i][j] = elems[rs[i] * 4 + cs[j]];
      d = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
        - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
        + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
      return ((r + c) & 1) ? -d : d;
   endfunction

   // note one accepted row; the fourth completes the matrix and queues its inverse
   function void note_row(logic signed [31:0] e [4]);
      logic signed [127:0] cof [16];
      logic signed [191:0] det;
      logic [255:0]        num;
      logic [255:0]        ad;
      logic [255:0]        quo;
      logic [1:0]          status;
      logic [31:0]         res [16];
      bit                  neg;
      inv_row_type         row;
      for (int i = 0; i < 4; i++) elems[rows_in * 4 + i] = e[i];
      if (rows_in != 3) begin
         rows_in++;
         return;
      end
      rows_in = 0;
      matrices++;
      det = 0;
      for (int i = 0; i < 16; i++) cof[i] = cofactor(i >> 2, i & 3);
      for (int i = 0; i < 4; i++) det += elems[i] * cof[i];
      status = mi4_pkg::STAT_OK;
      if (det == 0) begin
         status = mi4_pkg::STAT_SINGULAR;
         for (int i = 0; i < 16; i++) res[i] = 0;
      end else begin
         ad = (det < 0) ? -det : det;
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
               neg = (cof[c * 4 + r] < 0) != (det < 0);
               num = (cof[c * 4 + r] < 0) ? -cof[c * 4 + r] : cof[c * 4 + r];
               // round to nearest, ties away from zero
               quo = ((num << 33) + ad) / (ad << 1);
               if (neg) begin
                  if (quo > 256'h8000_0000) begin
                     quo = 256'h8000_0000;
                     status = mi4_pkg::STAT_SATURATED;
                  end
                  res[r * 4 + c] = 32'd0 - quo[31:0];
               end else begin
                  if (quo > 256'h7FFF_FFFF) begin
                     quo = 256'h7FFF_FFFF;
                     status = mi4_pkg::STAT_SATURATED;
                  end
                  res[r * 4 + c] = quo[31:0];
               end
            end
      end
      if (status == mi4_pkg::STAT_SINGULAR) singulars++;
      if (status == mi4_pkg::STAT_SATURATED) saturations++;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) row.res[c] = res[r * 4 + c];
         row.row_index = 2'(r);
         row.status = status;
         row.last = (r == 3);
         pending.push_back(row);
      end
   endfunction

   // compare one result row with the oldest expectation
   function void check_row(logic signed [31:0] got [4], logic [1:0] idx, logic [1:0] st,
                           logic lst);
      inv_row_type x;
      bit bad;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result row %0d", idx);
         return;
      end
      x = pending.pop_front();
      bad = (idx !== x.row_index) || (st !== x.status) || (lst !== x.last);
      for (int c = 0; c < 4; c++) if (got[c] !== x.res[c]) bad = 1;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("row mismatch: exp %h %h %h %h idx %0d st %0d last %0d",
                     x.res[0], x.res[1], x.res[2], x.res[3], x.row_index, x.status, x.last);
            $display("              got %h %h %h %h idx %0d st %0d last %0d",
                     got[0], got[1], got[2], got[3], idx, st, lst);
         end
      end
   endfunction
endclass

module tb_top;
   import mi4_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [ELEM_W-1:0] req_elem0, req_elem1, req_elem2, req_elem3;
   logic rsp_valid;
   logic signed [ELEM_W-1:0] rsp_res0, rsp_res1, rsp_res2, rsp_res3;
   logic [1:0] rsp_row_index;
   logic [1:0] rsp_status;
   logic rsp_last;

   inverse_scoreboard sb;
   int unsigned idle_pct;
   int unsigned quiet_cycles = 0;
   int unsigned rows_sent;

   matrix_inverse_4x4_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_elem0(req_elem0), .req_elem1(req_elem1),
      .req_elem2(req_elem2), .req_elem3(req_elem3),
      .rsp_valid(rsp_valid), .rsp_res0(rsp_res0), .rsp_res1(rsp_res1),
      .rsp_res2(rsp_res2), .rsp_res3(rsp_res3), .rsp_row_index(rsp_row_index),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // sample at the rising edge: accepted rows and results, watchdog
   always @(posedge clock) begin
      logic signed [31:0] e [4];
      logic signed [31:0] g [4];
      if (!reset) begin
         if (start && !busy) begin
            e = '{req_elem0, req_elem1, req_elem2, req_elem3};
            sb.note_row(e);
         end
         if (rsp_valid) begin
            g = '{rsp_res0, rsp_res1, rsp_res2, rsp_res3};
            sb.check_row(g, rsp_row_index, rsp_status, rsp_last);
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles > WATCHDOG) begin
            $display("watchdog expired");
            $display("** matrix_inverse_4x4_core: FAILED **");
            $finish;
         end
      end
   end

   // offer one row, holding it until accepted; start stays high for a following row
   task automatic send_row(logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] d);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_elem0 <= a;
      req_elem1 <= b;
      req_elem2 <= c;
      req_elem3 <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      rows_sent++;
   endtask

   // random element: mostly moderate Q16.16, sometimes raw extreme patterns
   function automatic logic signed [31:0] rand_elem();
      case ($urandom_range(9, 0))
         0: return $urandom;
         1: return '0;
         2: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         3: return $signed($urandom_range(7, 0)) - 4;
         default: return $signed($urandom_range(32'h0008_0000, 0)) - 32'sh0004_0000;
      endcase
   endfunction

   task automatic send_matrix(int kind);
      logic signed [31:0] m [16];
      for (int i = 0; i < 16; i++) m[i] = rand_elem();
      case (kind)
         1: for (int i = 0; i < 4; i++) m[8 + i] = m[4 + i];     // repeated row: singular
         2: for (int i = 0; i < 16; i++)                           // near-identity scaled
               m[i] = ((i % 5) == 0) ? $signed($urandom_range(32'h0002_0000, 1)) :
                      $signed($urandom_range(255, 0)) - 128;
         default: ;
      endcase
      for (int r = 0; r < 4; r++) send_row(m[r * 4], m[r * 4 + 1], m[r * 4 + 2], m[r * 4 + 3]);
   endtask

   initial begin
      sb = new();
      rows_sent = 0;
      idle_pct = 0;
      start = 0;
      req_elem0 = 0;
      req_elem1 = 0;
      req_elem2 = 0;
      req_elem3 = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: identity, singular zero, tiny diagonal (saturates), extremes, scaled
      send_row(32'sh1_0000, 0, 0, 0);
      send_row(0, 32'sh1_0000, 0, 0);
      send_row(0, 0, 32'sh1_0000, 0);
      send_row(0, 0, 0, 32'sh1_0000);
      repeat (4) send_row(0, 0, 0, 0);
      send_row(1, 0, 0, 0);
      send_row(0, 1, 0, 0);
      send_row(0, 0, -1, 0);
      send_row(0, 0, 0, 1);
      send_row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
      send_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
      send_row(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
      send_row(32'shFFFF_FFFF, 0, 32'sh5555_5555, 32'shAAAA_AAAA);
      send_row(32'sh2_0000, 32'sh1_0000, 0, 0);
      send_row(32'sh1_0000, 32'sh3_0000, 32'sh1_0000, 0);
      send_row(0, 32'sh1_0000, 32'sh4_0000, 32'sh1_0000);
      send_row(0, 0, 32'sh1_0000, 32'sh5_0000);
      start <= 0;

      // hold off until every expected row has arrived
      while (sb.pending.size() != 0) @(negedge clock);

      // random phases: no idle, sender idle 69%, sender idle 21%, then no idle again (receiver cannot stall)
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 69 : (ph == 2) ? 21 : 0;
         for (int k = 0; k < 27; k++) send_matrix($urandom_range(5, 0) == 0 ? 1 :
                                                  $urandom_range(2, 0) == 0 ? 2 : 0);
      end
      start <= 0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("sent %0d rows, %0d matrices: %0d singular, %0d saturated",
               rows_sent, sb.matrices, sb.singulars, sb.saturations);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("** matrix_inverse_4x4_core: PASSED **");
      else
         $display("** matrix_inverse_4x4_core: FAILED **");
      $finish;
   end
endmodule
